// ===== src/bsa_pkg.sv =====
package bsa_pkg;

  // Fixed geometry of the used map
  localparam int WORD_BITS     = 8;
  localparam int MAX_SLOTS_DEF = 256;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_SLOT_COUNT = 8'd0;
  localparam logic [7:0] REG_ELEM_BYTES = 8'd1;

  // Register reset values
  localparam logic [8:0]  SLOT_COUNT_RST = 9'd256;
  localparam logic [15:0] ELEM_BYTES_RST = 16'd1;

  // Map word with every slot taken
  localparam logic [WORD_BITS-1:0] FULL_WORD = 8'hff;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] slot;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  granted_slot;
    logic [23:0] byte_offset;
  } out_item_t;

  // Map word as rebuilt for a given slot count: slots at or past the count are used
  function automatic logic [WORD_BITS-1:0] init_word(input logic [31:0] base,
                                                     input logic [31:0] live);
    logic [WORD_BITS-1:0] w;
    w = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      w[b] = ((base + 32'(b)) >= live);
    end
    return w;
  endfunction

  // Position of the lowest clear bit of a map word
  function automatic logic [2:0] first_clear(input logic [WORD_BITS-1:0] w);
    logic [2:0] pos;
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!w[b]) begin
        pos = 3'(b);
      end
    end
    return pos;
  endfunction

endpackage

// ===== src/bsa_map_mem.sv =====
module bsa_map_mem #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
  localparam int MAP_WORDS = MAX_SLOTS / bsa_pkg::WORD_BITS,
  localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int CNT_W = ($clog2(MAX_SLOTS + 1) > 9) ? $clog2(MAX_SLOTS + 1) : 9
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             clear,
  input  logic [CNT_W-1:0]                 live,
  input  logic                             rd_en,
  input  logic [IDX_W-1:0]                 rd_addr,
  input  logic                             wr_en,
  input  logic [IDX_W-1:0]                 wr_addr,
  input  logic [bsa_pkg::WORD_BITS-1:0]    wr_data,
  output logic [bsa_pkg::WORD_BITS-1:0]    rd_word
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] vld;
  logic [WORD_BITS-1:0] rd_q;
  logic                 rd_vld;
  logic [IDX_W-1:0]     rd_idx;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q   <= mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  // Track which words hold written data since the last rebuild
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (rd_en) begin
      rd_vld <= vld[rd_addr];
    end
  end

  // Unwritten words read as the rebuilt pattern
  assign rd_word = rd_vld ? rd_q
                          : init_word(32'({rd_idx, 3'b000}), 32'(live));

endmodule

// ===== src/bsa_ctrl.sv =====
module bsa_ctrl #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
  localparam int MAP_WORDS = MAX_SLOTS / bsa_pkg::WORD_BITS,
  localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int SLOT_W = IDX_W + 3,
  localparam int CNT_W = ($clog2(MAX_SLOTS + 1) > 9) ? $clog2(MAX_SLOTS + 1) : 9
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [CNT_W-1:0]              live,
  input  logic [15:0]                   elem_bytes,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bsa_pkg::in_item_t             in_item,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bsa_pkg::out_item_t            res_item,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  output logic                          wr_en,
  output logic [IDX_W-1:0]              wr_addr,
  output logic [bsa_pkg::WORD_BITS-1:0] wr_data,
  input  logic [bsa_pkg::WORD_BITS-1:0] rd_word
);
  import bsa_pkg::*;

  localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(MAP_WORDS - 1);

  state_t              state, state_next;
  logic [IDX_W-1:0]    chk_idx;
  logic [IDX_W-1:0]    chk_inc;
  logic [2:0]          slot_bit;
  logic [SLOT_W-1:0]   granted;
  status_t             res_status;
  logic [23:0]         res_offset;
  logic                accept;
  logic                out_of_range;
  logic                word_free;
  logic [2:0]          free_pos;
  logic [SLOT_W+15:0]  prod;

  assign accept       = in_valid && !in_stall;
  assign out_of_range = (CNT_W'(in_item.slot) >= live);
  assign word_free    = (rd_word != FULL_WORD);
  assign free_pos     = first_clear(rd_word);
  assign chk_inc      = chk_idx + 1'b1;
  assign prod         = (SLOT_W + 16)'(granted) * (SLOT_W + 16)'(elem_bytes);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory access and handshake
  always_comb begin
    state_next = state;
    in_stall   = (state != S_IDLE);
    res_valid  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = chk_inc;
    wr_en      = 1'b0;
    wr_addr    = chk_idx;
    wr_data    = rd_word | (WORD_BITS'(1) << free_pos);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_item.action == ACT_ALLOC) begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_SCAN;
          end else if (out_of_range) begin
            state_next = S_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = IDX_W'(in_item.slot >> 3);
            state_next = S_FREE;
          end
        end
      end
      S_SCAN: begin
        if (word_free) begin
          wr_en      = 1'b1;
          state_next = S_MUL;
        end else if (chk_idx == LAST_WORD) begin
          state_next = S_DONE;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_FREE: begin
        wr_en      = 1'b1;
        wr_data    = rd_word & ~(WORD_BITS'(1) << slot_bit);
        state_next = S_DONE;
      end
      S_MUL: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Working registers of the item in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      chk_idx    <= (in_item.action == ACT_ALLOC) ? '0 : IDX_W'(in_item.slot >> 3);
      slot_bit   <= in_item.slot[2:0];
      granted    <= '0;
      res_offset <= '0;
      res_status <= (in_item.action == ACT_FREE && out_of_range) ? ST_RANGE : ST_OK;
    end else begin
      case (state)
        S_SCAN: begin
          if (word_free) begin
            granted <= {chk_idx, free_pos};
          end else if (chk_idx == LAST_WORD) begin
            res_status <= ST_FULL;
          end else begin
            chk_idx <= chk_inc;
          end
        end
        S_MUL: begin
          res_offset <= 24'(prod);
        end
        default: begin
        end
      endcase
    end
  end

  assign res_item.status       = res_status;
  assign res_item.granted_slot = 8'(granted);
  assign res_item.byte_offset  = res_offset;

endmodule

// ===== src/bsa_out.sv =====
module bsa_out (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  bsa_pkg::out_item_t res_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bsa_pkg::out_item_t out_item
);
  import bsa_pkg::*;

  // Take a new result whenever the register is empty or draining
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item <= res_item;
    end
  end

endmodule

// ===== src/bitmap_slot_allocator.sv =====
// Bitmap slot allocator: hands out and takes back slots of a fixed-element pool.
// Input channel (in_valid / in_stall / in_item): one request per item, either
// allocate (lowest free slot) or free (the slot given in the item).
// Output channel (out_valid / out_stall / out_item): exactly one result per
// request with status, granted slot and its byte offset (slot * elem_bytes).
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0
// sets slot_count and rebuilds the map, index 1 sets elem_bytes. Always ready.
// Structure: the used map sits in a one-port-read synchronous memory of 8-bit
// words. An allocate reads one word per cycle from word 0 up until a word has
// a clear bit, writes that word back with the bit set and then reckons the
// byte offset; a full pool ends after the last word. A free is a
// read-modify-write, and an out-of-range free goes straight to the result.
// One request is in flight at a time; the next is accepted once the result
// has moved into the output register.
// Reset: slot_count 256, elem_bytes 1, all slots below the count free. The map
// rebuild is instant (per-word written flags), so no clearing pass is needed.
// A stalled result holds in the output register while the next request runs.
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
  localparam int MAP_WORDS = MAX_SLOTS / bsa_pkg::WORD_BITS,
  localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1,
  localparam int CNT_W = ($clog2(MAX_SLOTS + 1) > 9) ? $clog2(MAX_SLOTS + 1) : 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsa_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output bsa_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import bsa_pkg::*;

  logic [8:0]           slot_count;
  logic [15:0]          elem_bytes;
  logic [CNT_W-1:0]     live;
  logic                 map_clear;
  logic                 res_valid;
  logic                 res_ready;
  out_item_t            res_item;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] rd_word;

  assign cfg_ready = 1'b1;
  assign map_clear = cfg_valid && cfg_ready && (cfg_index == REG_SLOT_COUNT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= SLOT_COUNT_RST;
      elem_bytes <= ELEM_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SLOT_COUNT: slot_count <= cfg_data[8:0];
        REG_ELEM_BYTES: elem_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturate the count at the pool size
  assign live = (CNT_W'(slot_count) > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
                                                         : CNT_W'(slot_count);

  bsa_map_mem #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .clear   (map_clear),
    .live    (live),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_word (rd_word)
  );

  bsa_ctrl #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .live       (live),
    .elem_bytes (elem_bytes),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_word    (rd_word)
  );

  bsa_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== src/bsa_checker.sv =====
module bsa_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input bsa_pkg::out_item_t out_item
);
  import bsa_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Error results carry no grant
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != ST_OK) |->
      (out_item.granted_slot == 8'd0) && (out_item.byte_offset == 24'd0))
    else $error("error result with nonzero grant");

  // One request at a time: busy right after taking one
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bsa_pkg::*;

  localparam int POOL_SLOTS  = MAX_SLOTS_DEF;
  // Longest request is a full-pool scan; leave margin
  localparam int TAIL_CYCLES = 48;
  localparam int QUIET_LIMIT = 4000;
  // Index past the register list, written to confirm it is ignored
  localparam logic [7:0] REG_UNUSED = 8'hff;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS,
    STALL_EVERY_THIRD
  } stall_mode_t;

  // One row of the directed plan: a register write or a request
  typedef struct {
    bit         is_cfg;
    logic [7:0] reg_idx;
    logic [15:0] reg_data;
    in_item_t   req;
    bit         known;
    out_item_t  want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Allocator shadow state
  bit [POOL_SLOTS-1:0] slot_used;
  int                  live_slots;
  logic [15:0]         unit_bytes;

  out_item_t pending_results[$];
  out_item_t head_result;
  plan_row_t plan[$];

  int burst_left = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_requests = 0;
  int n_writes = 0;
  int n_granted = 0;
  int n_full = 0;
  int n_range = 0;
  int quiet_cycles = 0;

  stall_mode_t stall_mode = STALL_NONE;
  int          stall_tick = 0;
  int          stall_run = 0;
  bit          stall_hold = 1'b0;

  bitmap_slot_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rebuild the map: slots below the count free, the rest used
  function automatic void rebuild_pool(logic [8:0] count);
    live_slots = (int'(count) > POOL_SLOTS) ? POOL_SLOTS : int'(count);
    for (int s = 0; s < POOL_SLOTS; s++) begin
      slot_used[s] = (s >= live_slots);
    end
  endfunction

  // Apply one request to the shadow map and return the result it yields
  function automatic out_item_t serve_request(in_item_t req);
    out_item_t res;
    bit        hit;
    res = '0;
    res.status = ST_OK;
    hit = 1'b0;
    if (req.action == ACT_ALLOC) begin
      // Word-order scan with lowest bit first is a plain linear scan
      for (int s = 0; s < POOL_SLOTS; s++) begin
        if (!hit && !slot_used[s]) begin
          slot_used[s] = 1'b1;
          hit = 1'b1;
          res.granted_slot = 8'(s);
          res.byte_offset = 24'(s * int'(unit_bytes));
        end
      end
      if (!hit) begin
        res.status = ST_FULL;
      end
    end else if (int'(req.slot) >= live_slots) begin
      res.status = ST_RANGE;
    end else begin
      slot_used[req.slot] = 1'b0;
    end
    return res;
  endfunction

  // Pick an in-range slot that is currently held, else any slot
  function automatic logic [7:0] held_slot();
    int start;
    int s;
    start = $urandom_range(0, POOL_SLOTS - 1);
    for (int k = 0; k < POOL_SLOTS; k++) begin
      s = (start + k) % POOL_SLOTS;
      if (s < live_slots && slot_used[s]) begin
        return 8'(s);
      end
    end
    return 8'($urandom);
  endfunction

  function automatic plan_row_t cfg_row(logic [7:0] idx, logic [15:0] data);
    plan_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, reg_data: data, req: '0, known: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t req_row(action_t act, logic [7:0] slot, bit known = 1'b0,
                                        status_t st = ST_OK, logic [7:0] gs = '0,
                                        logic [23:0] off = '0);
    plan_row_t row;
    row = '{is_cfg: 1'b0, reg_idx: '0, reg_data: '0, req: '0, known: known, want: '0};
    row.req.action = act;
    row.req.slot = slot;
    row.want.status = st;
    row.want.granted_slot = gs;
    row.want.byte_offset = off;
    return row;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    n_errors++;
    if (n_errors <= 30) begin
      $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // Send one request in bursts with random gaps; queue its result on acceptance
  task automatic issue_request(in_item_t req, bit known, out_item_t want);
    out_item_t guess;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (in_stall);
    guess = serve_request(req);
    pending_results.push_back(known ? want : guess);
    n_requests++;
    burst_left--;
  endtask

  // Drop valid and wait until every queued result has been checked
  task automatic settle_pool();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [7:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SLOT_COUNT) begin
      rebuild_pool(data[8:0]);
    end else if (idx == REG_ELEM_BYTES) begin
      unit_bytes = data;
    end
    n_writes++;
    // Let the channel go idle before anything else drives it
    @(posedge clk);
  endtask

  // Receiver stall pattern: switches at random among the stall modes
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 97 == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall <= ($urandom_range(0, 2) == 0);
      end
      STALL_RUNS: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run = stall_hold ? $urandom_range(1, 20) : $urandom_range(1, 8);
        end else begin
          stall_run--;
        end
        out_stall <= stall_hold;
      end
      default: begin
        out_stall <= (stall_tick % 3 == 0);
      end
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending, status", out_item.status, 0);
      end else begin
        head_result = pending_results.pop_front();
        n_checked++;
        if (out_item.status !== head_result.status) begin
          flag_mismatch("status", out_item.status, head_result.status);
        end
        if (out_item.granted_slot !== head_result.granted_slot) begin
          flag_mismatch("granted_slot", out_item.granted_slot, head_result.granted_slot);
        end
        if (out_item.byte_offset !== head_result.byte_offset) begin
          flag_mismatch("byte_offset", out_item.byte_offset, head_result.byte_offset);
        end
        case (head_result.status)
          ST_OK:    if (head_result.granted_slot != 0 || head_result.byte_offset != 0) n_granted++;
          ST_FULL:  n_full++;
          default:  n_range++;
        endcase
      end
    end
  end

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t    req;
    out_item_t   blank;
    int          len;
    int          alloc_pct;
    logic [15:0] count_data;
    logic [15:0] size_data;

    blank = '0;
    rebuild_pool(SLOT_COUNT_RST);
    unit_bytes = ELEM_BYTES_RST;

    // Directed plan: reset state, extremes of size and count, error codes
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_OK, 8'd0, 24'd0));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_OK, 8'd1, 24'd1));
    plan.push_back(req_row(ACT_FREE, 8'd255, 1'b1, ST_OK));
    plan.push_back(req_row(ACT_FREE, 8'd0, 1'b1, ST_OK));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_OK, 8'd0, 24'd0));
    plan.push_back(cfg_row(REG_ELEM_BYTES, 16'hffff));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_OK, 8'd2, 24'd131070));
    plan.push_back(req_row(ACT_FREE, 8'd1, 1'b1, ST_OK));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_OK, 8'd1, 24'd65535));
    // Empty pool: everything full or out of range
    plan.push_back(cfg_row(REG_SLOT_COUNT, 16'h0000));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_FULL));
    plan.push_back(req_row(ACT_FREE, 8'd0, 1'b1, ST_RANGE));
    plan.push_back(req_row(ACT_FREE, 8'd255, 1'b1, ST_RANGE));
    plan.push_back(cfg_row(REG_SLOT_COUNT, 16'h0001));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_OK, 8'd0, 24'd0));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_FULL));
    plan.push_back(req_row(ACT_FREE, 8'd1, 1'b1, ST_RANGE));
    // Count of eight: the whole first word must be usable
    plan.push_back(cfg_row(REG_SLOT_COUNT, 16'h0008));
    repeat (8) plan.push_back(req_row(ACT_ALLOC, 8'd0));
    plan.push_back(req_row(ACT_ALLOC, 8'd0, 1'b1, ST_FULL));
    plan.push_back(req_row(ACT_FREE, 8'd7, 1'b1, ST_OK));
    // Unknown index ignored; a count past the pool saturates
    plan.push_back(cfg_row(REG_UNUSED, 16'h0003));
    plan.push_back(cfg_row(REG_SLOT_COUNT, 16'h812c));
    plan.push_back(req_row(ACT_FREE, 8'd255, 1'b1, ST_OK));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle_pool();
        write_register(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        issue_request(plan[i].req, plan[i].known, plan[i].want);
      end
    end

    // Random phases; the first fills the whole pool at the largest size
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 0) begin
        count_data = 16'(SLOT_COUNT_RST);
        size_data = 16'hffff;
        len = 262;
        alloc_pct = 100;
      end else begin
        case ($urandom_range(0, 7))
          0: count_data = 16'd0;
          1: count_data = 16'd1;
          2: count_data = 16'(8 * $urandom_range(1, 4));
          3: count_data = 16'($urandom_range(2, 40));
          4: count_data = 16'd255;
          5: count_data = 16'd256;
          6: count_data = 16'($urandom);
          default: count_data = 16'($urandom_range(257, 511));
        endcase
        case ($urandom_range(0, 3))
          0: size_data = 16'd1;
          1: size_data = 16'hffff;
          2: size_data = 16'd0;
          default: size_data = 16'($urandom);
        endcase
        len = $urandom_range(40, 56);
        alloc_pct = $urandom_range(35, 85);
      end
      settle_pool();
      write_register(REG_SLOT_COUNT, count_data);
      write_register(REG_ELEM_BYTES, size_data);
      for (int n = 0; n < len; n++) begin
        req = '0;
        if ($urandom_range(0, 99) < alloc_pct) begin
          req.action = ACT_ALLOC;
          req.slot = 8'($urandom);
        end else begin
          req.action = ACT_FREE;
          req.slot = ($urandom_range(0, 9) < 7) ? held_slot() : 8'($urandom);
        end
        issue_request(req, 1'b0, blank);
      end
    end

    // Drain, then let the block run out
    settle_pool();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_mismatch("results never delivered", 0, pending_results.size());
    end

    $display("Covered %0d requests over %0d register writes: %0d nonzero grants,",
             n_requests, n_writes, n_granted);
    $display("%0d pool full, %0d out of range; checked %0d results, %0d mismatches.",
             n_full, n_range, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
